// ===== rtl/core/tddc_pkg.sv =====
// shared constants, command/status structs and state type for the divisor counter
`default_nettype none

package tddc_pkg;

    // width of the value that is examined
    localparam int VALUE_BITS   = 31;
    // fixed field widths of the streams
    localparam int NUMBER_BITS  = 31;
    localparam int COUNT_BITS   = 12;
    localparam int S_TDATA_BITS = ((NUMBER_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((COUNT_BITS + 1 + 7) / 8) * 8;

    // candidate, running square, partial remainder and bit index widths
    localparam int CAND_BITS    = VALUE_BITS / 2 + 1;
    localparam int SQ_BITS      = 2 * CAND_BITS;
    localparam int REM_BITS     = CAND_BITS + 1;
    localparam int BIT_IDX_BITS = $clog2(VALUE_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } tddc_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic acc;
        logic result_load;
    } tddc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic sq_le_n;
        logic div_last;
    } tddc_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/trial_division_divisor_counter.sv =====
// top level of the trial-division divisor counter
// Takes one word holding a value n and returns one word with the number of positive
// divisors of n and a prime flag (0 divisors for n = 0, 1 for n = 1). Candidates i run
// from 2 while i*i <= n; the square is kept by adding 2i+1, so no multiplier is used.
// Each candidate takes one pass of a one-bit-per-cycle restoring remainder unit over
// every bit of n, plus a check state and an accumulate state. One word is worked on
// at a time; a new word is taken as soon as the previous result sits in the output
// register, even if it has not been taken yet.
`default_nettype none

module trial_division_divisor_counter
    import tddc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,   // [30:0] number
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_BITS-1:0]      m_tdata    // [11:0] divisor_count, [12] prime_flag
);

    tddc_cmd_t             cmd;
    tddc_status_t          status;
    logic [COUNT_BITS-1:0] m_count;
    logic                  m_prime;

    // sequencing
    tddc_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic
    tddc_datapath u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .number  (s_tdata[NUMBER_BITS-1:0]),
        .status  (status),
        .m_count (m_count),
        .m_prime (m_prime)
    );

    // pack the result word
    assign m_tdata = M_TDATA_BITS'({m_prime, m_count});

endmodule

`default_nettype wire

// ===== rtl/core/tddc_datapath.sv =====
// datapath: candidate and square tracking, bit-serial remainder, divisor count
`default_nettype none

module tddc_datapath
    import tddc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire tddc_cmd_t              cmd,
    input  wire logic [NUMBER_BITS-1:0] number,
    output tddc_status_t                status,
    output logic [COUNT_BITS-1:0]       m_count,
    output logic                        m_prime
);

    logic [VALUE_BITS-1:0]   n_reg;
    logic [CAND_BITS-1:0]    cand_reg;
    logic [SQ_BITS-1:0]      sq_reg;
    logic [REM_BITS-1:0]     rem_reg;
    logic [BIT_IDX_BITS-1:0] bit_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   m_count_reg;
    logic                    m_prime_reg;

    logic [VALUE_BITS-1:0]   n_in;
    logic [COUNT_BITS-1:0]   count_init;
    logic [REM_BITS-1:0]     shifted;
    logic [REM_BITS-1:0]     rem_next;
    logic [COUNT_BITS:0]     count_sum;
    logic [COUNT_BITS-1:0]   count_next;
    logic                    is_root;
    logic                    prime;

    // incoming value, bits above the examined width dropped
    assign n_in = VALUE_BITS'(number);

    // 1 and n are divisors from the start; zero and one are special
    always_comb begin
        if (n_in == '0) begin
            count_init = '0;
        end else if (n_in == VALUE_BITS'(1)) begin
            count_init = COUNT_BITS'(1);
        end else begin
            count_init = COUNT_BITS'(2);
        end
    end

    // one restoring remainder step, msb of n first
    assign shifted  = {rem_reg[REM_BITS-2:0], n_reg[bit_reg]};
    assign rem_next = (shifted >= REM_BITS'(cand_reg)) ? shifted - REM_BITS'(cand_reg)
                                                       : shifted;

    // a divisor equal to its cofactor is the square root, counted once
    assign is_root   = (sq_reg == SQ_BITS'(n_reg));
    assign count_sum = {1'b0, count_reg} + (is_root ? (COUNT_BITS + 1)'(1)
                                                    : (COUNT_BITS + 1)'(2));
    assign count_next = count_sum[COUNT_BITS] ? COUNT_MAX : count_sum[COUNT_BITS-1:0];

    assign prime = (n_reg >= VALUE_BITS'(2)) && (count_reg == COUNT_BITS'(2));

    // status back to the controller
    assign status.sq_le_n  = (sq_reg <= SQ_BITS'(n_reg));
    assign status.div_last = (bit_reg == '0);

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg     <= n_in;
            cand_reg  <= CAND_BITS'(2);
            sq_reg    <= SQ_BITS'(4);
            count_reg <= count_init;
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            bit_reg <= BIT_IDX_BITS'(VALUE_BITS - 1);
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            bit_reg <= bit_reg - BIT_IDX_BITS'(1);
        end
        if (cmd.acc) begin
            if (rem_reg == '0) begin
                count_reg <= count_next;
            end
            cand_reg <= cand_reg + CAND_BITS'(1);
            sq_reg   <= sq_reg + SQ_BITS'({cand_reg, 1'b0}) + SQ_BITS'(1);
        end
        if (cmd.result_load) begin
            m_count_reg <= count_reg;
            m_prime_reg <= prime;
        end
    end

    assign m_count = m_count_reg;
    assign m_prime = m_prime_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tddc_controller.sv =====
// controller: sequences load, trial loop and result hand-off
`default_nettype none

module tddc_controller
    import tddc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire tddc_status_t status,
    output tddc_cmd_t         cmd
);

    tddc_state_t state_reg;
    tddc_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    // state and output word valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.sq_le_n ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                // no word is taken while reset is held
                s_tready = aresetn;
                cmd.load = s_tvalid;
            end
            ST_CHECK: begin
                cmd.div_init = status.sq_le_n;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.div_init, cmd.div_step, cmd.acc, cmd.result_load}))
        else $error("more than one datapath command at once");

    // a waiting result word is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !cmd.result_load)
        else $error("result word overwritten while stalled");

    // an accepted word starts the candidate loop
    a_load_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted word did not start the loop");

    // every remainder pass ends with an accumulate step
    a_div_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && status.div_last) |=> cmd.acc)
        else $error("remainder pass not followed by accumulate");

endmodule

`default_nettype wire
